@@ hw/rtl/order_book_snapshot_diff_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Order book snapshot differ: assertion macros
// Shared macros for the concurrent checks of the unit.
// ----------------------------------------------------------------------------
`ifndef ORDER_BOOK_SNAPSHOT_DIFF_UNIT_DEFINES_SVH
`define ORDER_BOOK_SNAPSHOT_DIFF_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define OBSD_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("check failed");
`define OBSD_ASSERT_NEXT(lbl, clk, rstn, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error("check failed");
`else
`define OBSD_ASSERT(lbl, clk, rstn, prop)
`define OBSD_ASSERT_NEXT(lbl, clk, rstn, a, b)
`endif
`endif

@@ hw/rtl/obsd_pkg.sv @@
// ----------------------------------------------------------------------------
// Order book snapshot differ package
// Depth constants and the types shared by the front and back parts.
// ----------------------------------------------------------------------------
package obsd_pkg;
	localparam int BOOK_DEPTH = 16;
	localparam int IDX_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
	localparam int CNT_W = $clog2(BOOK_DEPTH + 1);
	localparam int FIFO_DEPTH = 2;

	typedef struct packed {
		logic        side;
		logic [62:0] price;
		logic [62:0] qty;
		logic        lvl;
		logic        fin;
		logic [63:0] time_ns;
	} cmd_t;

	typedef struct packed {
		logic [63:0] seq;
		logic [62:0] price;
		logic [62:0] qty;
		logic        side;
		logic        snap;
		logic        start;
		logic [63:0] time_ns;
		logic        last;
	} ev_t;
endpackage

@@ hw/rtl/obsd_front.sv @@
// ----------------------------------------------------------------------------
// Front part
// Accepts requests, drops bare ones and queues the rest for the back part.
// ----------------------------------------------------------------------------
module obsd_front import obsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  cmd_t        item,
	output logic        cmd_v,
	output cmd_t        cmd,
	input  logic        cmd_pop
);
	cmd_t       mem_q [FIFO_DEPTH];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       keep;

	assign full  = (cnt_q == 2'(FIFO_DEPTH));
	// A request with neither a level nor an end mark changes nothing.
	assign keep  = push && !full && (item.lvl || item.fin);
	assign cmd_v = (cnt_q != 2'd0);
	assign cmd   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (keep) begin
			mem_q[wp_q] <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (keep) begin
				wp_q <= ~wp_q;
			end
			if (cmd_pop && cmd_v) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(keep) - 2'(cmd_pop && cmd_v);
		end
	end
endmodule

@@ hw/rtl/obsd_back.sv @@
// ----------------------------------------------------------------------------
// Back part
// Sorted level tables, the insert walk, the diff walk and the event queue.
// ----------------------------------------------------------------------------
`include "order_book_snapshot_diff_unit_defines.svh"
module obsd_back import obsd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_v,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic ev_v,
	output ev_t  ev,
	input  logic ev_pop
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INS  = 3'd1;
	localparam logic [2:0] ST_NEW  = 3'd2;
	localparam logic [2:0] ST_GONE = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	// Tables are numbered {side, bank}; sel_q[side] names the bank holding the
	// previous snapshot, the other bank collects the current one.
	logic [62:0]      px_q [4][BOOK_DEPTH];
	logic [62:0]      qt_q [4][BOOK_DEPTH];
	logic [CNT_W-1:0] cnt_q [4];
	logic [1:0]       sel_q;
	logic [2:0]       st_q;
	logic             side_q;
	logic [CNT_W-1:0] i_q, j_q;
	logic [63:0]      seq_q;
	logic             first_q, none_q;
	logic             pend_v_q, out_v_q;
	ev_t              pend_q, out_q;

	logic [1:0]       ta, tb, t_ins, t_new, t_old;
	logic [62:0]      a_px, a_qt, b_px, b_qt;
	logic [CNT_W-1:0] n_a, n_b;
	logic             can_emit, emit, fin_fire, a_end, b_end, hit;
	logic [62:0]      emit_qt;
	ev_t              ev_new;
	ev_t              pend_fwd;

	assign t_ins = {cmd.side, ~sel_q[cmd.side]};
	assign t_new = {side_q, ~sel_q[side_q]};
	assign t_old = {side_q, sel_q[side_q]};

	always_comb begin
		ta = t_ins;
		tb = t_old;
		case (st_q)
			ST_NEW: begin
				ta = t_new;
				tb = t_old;
			end
			ST_GONE: begin
				ta = t_old;
				tb = t_new;
			end
			default: begin
				ta = t_ins;
				tb = t_old;
			end
		endcase
	end

	assign a_px  = px_q[ta][i_q[IDX_W-1:0]];
	assign a_qt  = qt_q[ta][i_q[IDX_W-1:0]];
	assign b_px  = px_q[tb][j_q[IDX_W-1:0]];
	assign b_qt  = qt_q[tb][j_q[IDX_W-1:0]];
	assign n_a   = cnt_q[ta];
	assign n_b   = cnt_q[tb];
	assign a_end = (i_q == n_a);
	assign b_end = (j_q == n_b);
	assign hit   = (a_px == b_px);

	assign can_emit = !pend_v_q || !out_v_q || ev_pop;

	always_comb begin
		emit    = 1'b0;
		emit_qt = a_qt;
		case (st_q)
			ST_NEW: begin
				emit = !a_end && (b_end || (hit && (a_qt != b_qt)));
			end
			ST_GONE: begin
				emit    = !a_end && b_end;
				emit_qt = '0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign fin_fire = (st_q == ST_FIN) && can_emit;
	assign cmd_pop  = fin_fire || ((st_q == ST_INS) && !cmd.fin &&
		!((i_q < n_a) && (a_px < cmd.price)));

	always_comb begin
		ev_new.seq     = seq_q;
		ev_new.price   = a_px;
		ev_new.qty     = emit_qt;
		ev_new.side    = side_q;
		ev_new.snap    = first_q;
		ev_new.start   = first_q && none_q;
		ev_new.time_ns = cmd.time_ns;
		ev_new.last    = 1'b0;
	end

	// The held event leaves flagged as the last one when the run finishes.
	always_comb begin
		pend_fwd      = pend_q;
		pend_fwd.last = fin_fire;
	end

	// Table contents carry no reset; only entries below a count are read.
	always_ff @(posedge clk) begin
		if ((st_q == ST_INS) && !((i_q < n_a) && (a_px < cmd.price))) begin
			if ((i_q < n_a) && (a_px == cmd.price)) begin
				qt_q[t_ins][i_q[IDX_W-1:0]] <= cmd.qty;
			end else if (n_a < CNT_W'(BOOK_DEPTH)) begin
				for (int k = BOOK_DEPTH - 1; k > 0; k--) begin
					if ((CNT_W'(k) > i_q) && (CNT_W'(k) <= n_a)) begin
						px_q[t_ins][IDX_W'(k)] <= px_q[t_ins][IDX_W'(k-1)];
						qt_q[t_ins][IDX_W'(k)] <= qt_q[t_ins][IDX_W'(k-1)];
					end
				end
				px_q[t_ins][i_q[IDX_W-1:0]] <= cmd.price;
				qt_q[t_ins][i_q[IDX_W-1:0]] <= cmd.qty;
			end
		end
		if (emit && can_emit) begin
			pend_q <= ev_new;
		end
		if (pend_v_q && ((emit && can_emit) || fin_fire)) begin
			out_q <= pend_fwd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			side_q   <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			sel_q    <= '0;
			for (int t = 0; t < 4; t++) begin
				cnt_q[2'(t)] <= '0;
			end
			seq_q    <= '0;
			first_q  <= 1'b1;
			none_q   <= 1'b1;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (pend_v_q && ((emit && can_emit) || fin_fire)) begin
				out_v_q <= 1'b1;
			end else if (ev_pop && out_v_q) begin
				out_v_q <= 1'b0;
			end
			if (emit && can_emit) begin
				pend_v_q <= 1'b1;
				seq_q    <= seq_q + 64'd1;
				none_q   <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					i_q    <= '0;
					j_q    <= '0;
					side_q <= 1'b0;
					if (cmd_v) begin
						st_q <= cmd.lvl ? ST_INS : ST_NEW;
					end
				end
				ST_INS: begin
					if ((i_q < n_a) && (a_px < cmd.price)) begin
						i_q <= i_q + 1'b1;
					end else begin
						if (!((i_q < n_a) && (a_px == cmd.price)) &&
							(n_a < CNT_W'(BOOK_DEPTH))) begin
							cnt_q[t_ins] <= n_a + 1'b1;
						end
						i_q    <= '0;
						j_q    <= '0;
						side_q <= 1'b0;
						st_q   <= cmd.fin ? ST_NEW : ST_IDLE;
					end
				end
				ST_NEW, ST_GONE: begin
					if (a_end) begin
						i_q <= '0;
						j_q <= '0;
						if (st_q == ST_NEW) begin
							st_q <= ST_GONE;
						end else if (!side_q) begin
							side_q <= 1'b1;
							st_q   <= ST_NEW;
						end else begin
							st_q <= ST_FIN;
						end
					end else if (b_end || hit) begin
						if (!emit || can_emit) begin
							i_q <= i_q + 1'b1;
							j_q <= '0;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (can_emit) begin
						pend_v_q <= 1'b0;
						sel_q    <= ~sel_q;
						cnt_q[{1'b0, sel_q[0]}] <= '0;
						cnt_q[{1'b1, sel_q[1]}] <= '0;
						first_q  <= 1'b0;
						st_q     <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign ev_v = out_v_q;
	assign ev   = out_q;

	`OBSD_ASSERT(a_pend_in_diff, clk, arst_n, pend_v_q |-> (st_q == ST_NEW || st_q == ST_GONE || st_q == ST_FIN))
	`OBSD_ASSERT(a_walk_bound, clk, arst_n, (st_q == ST_INS) |-> (i_q <= n_a))
	`OBSD_ASSERT(a_start_first, clk, arst_n, (emit && ev_new.start) |-> first_q)
	`OBSD_ASSERT_NEXT(a_fin_idle, clk, arst_n, fin_fire, (st_q == ST_IDLE) && !pend_v_q)
endmodule

@@ hw/rtl/order_book_snapshot_diff_unit.sv @@
// ----------------------------------------------------------------------------
// Order book snapshot differ, top level
// Loads price-level snapshots and emits the level changes against the last.
// ----------------------------------------------------------------------------
// Input requests arrive as a queue: push with full. A request carries a level,
// an end mark, both, or neither; bare ones are dropped. A level is placed into
// the sorted bid or ask table by walking it, one entry per cycle. An end mark
// starts the diff, which compares each current level against the previous
// levels, then each previous level against the current ones, one pair per
// cycle while the event queue has room. Events leave through a queue: empty
// with pop. Each event waits in a pending register until the next event or
// the end of the run, so its last_of_run flag is known when shown. A two-entry
// request queue lets the sender run ahead while the back part is walking;
// when the receiver stalls, the diff pauses and nothing is lost. Reset empties
// every table, zeroes the sequence counter and makes the next snapshot a
// Snapshot-kind run. The symbol register is written with cfg_we and cfg_wdata;
// the user must do this only while the unit is idle, which is not enforced.
// ----------------------------------------------------------------------------
module order_book_snapshot_diff_unit import obsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        push,
	output logic        full,
	input  logic        book_side,
	input  logic [62:0] level_price,
	input  logic [62:0] level_qty,
	input  logic        carries_level,
	input  logic        snapshot_end,
	input  logic [63:0] snapshot_time_ns,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] event_sequence,
	output logic [62:0] event_price,
	output logic [62:0] event_qty,
	output logic        event_side,
	output logic        is_snapshot_kind,
	output logic        start_marker,
	output logic [63:0] event_time_ns,
	output logic [31:0] event_symbol,
	output logic        last_of_run
);
	logic [31:0] symbol_q;
	cmd_t        item, cmd;
	logic        cmd_v, cmd_pop, ev_v;
	ev_t         ev;

	// The symbol is copied into every event as it leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_q <= '0;
		end else if (cfg_we) begin
			symbol_q <= cfg_wdata;
		end
	end

	always_comb begin
		item.side    = book_side;
		item.price   = level_price;
		item.qty     = level_qty;
		item.lvl     = carries_level;
		item.fin     = snapshot_end;
		item.time_ns = snapshot_time_ns;
	end

	obsd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.cmd_v   (cmd_v),
		.cmd     (cmd),
		.cmd_pop (cmd_pop)
	);

	obsd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd_v   (cmd_v),
		.cmd     (cmd),
		.cmd_pop (cmd_pop),
		.ev_v    (ev_v),
		.ev      (ev),
		.ev_pop  (pop)
	);

	assign empty            = !ev_v;
	assign event_sequence   = ev.seq;
	assign event_price      = ev.price;
	assign event_qty        = ev.qty;
	assign event_side       = ev.side;
	assign is_snapshot_kind = ev.snap;
	assign start_marker     = ev.start;
	assign event_time_ns    = ev.time_ns;
	assign event_symbol     = symbol_q;
	assign last_of_run      = ev.last;
endmodule

@@ tb/order_book_snapshot_diff_unit_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book snapshot differ: event checker
// Watches the request and event queues, predicts the events and compares them.
// ----------------------------------------------------------------------------
module order_book_snapshot_diff_unit_checker import obsd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        push,
	input  logic        full,
	input  logic        book_side,
	input  logic [62:0] level_price,
	input  logic [62:0] level_qty,
	input  logic        carries_level,
	input  logic        snapshot_end,
	input  logic [63:0] snapshot_time_ns,
	input  logic        empty,
	input  logic        pop,
	input  logic [63:0] event_sequence,
	input  logic [62:0] event_price,
	input  logic [62:0] event_qty,
	input  logic        event_side,
	input  logic        is_snapshot_kind,
	input  logic        start_marker,
	input  logic [63:0] event_time_ns,
	input  logic [31:0] event_symbol,
	input  logic        last_of_run,
	output int          fail_count,
	output int          pending_events
);
	typedef struct {
		ev_t         ev;
		logic [31:0] sym;
	} book_event_t;

	book_event_t  expected_events[$];
	logic [62:0]  prev_px[2][BOOK_DEPTH], prev_qt[2][BOOK_DEPTH];
	logic [62:0]  cur_px[2][BOOK_DEPTH], cur_qt[2][BOOK_DEPTH];
	int           prev_n[2], cur_n[2];
	logic [63:0]  seq_next;
	logic         first_pending, none_emitted;
	logic [31:0]  symbol;

	assign pending_events = expected_events.size();

	function automatic int find_level(logic [62:0] px[BOOK_DEPTH], int n, logic [62:0] p);
		for (int i = 0; i < n; i++)
			if (px[i] == p)
				return i;
		return -1;
	endfunction

	task automatic insert_level(int s, logic [62:0] p, logic [62:0] q);
		int i;
		i = 0;
		while (i < cur_n[s] && cur_px[s][i] < p)
			i++;
		if (i < cur_n[s] && cur_px[s][i] == p) begin
			cur_qt[s][i] = q;
			return;
		end
		if (cur_n[s] >= BOOK_DEPTH)
			return;
		for (int k = cur_n[s]; k > i; k--) begin
			cur_px[s][k] = cur_px[s][k-1];
			cur_qt[s][k] = cur_qt[s][k-1];
		end
		cur_px[s][i] = p;
		cur_qt[s][i] = q;
		cur_n[s]++;
	endtask

	task automatic add_event(int s, logic [62:0] p, logic [62:0] q, logic [63:0] ts);
		book_event_t e;
		e.ev.seq = seq_next;
		e.ev.price = p;
		e.ev.qty = q;
		e.ev.side = s[0];
		e.ev.snap = first_pending;
		e.ev.start = first_pending && none_emitted;
		e.ev.time_ns = ts;
		e.ev.last = 1'b0;
		e.sym = symbol;
		expected_events.insert(expected_events.size(), e);
		seq_next++;
		none_emitted = 1'b0;
	endtask

	// Builds the events of one finished snapshot: per side, changed or new
	// levels first, then vanished levels with zero quantity.
	task automatic diff_snapshot(logic [63:0] ts);
		int j, n_earlier;
		n_earlier = expected_events.size();
		for (int s = 0; s < 2; s++) begin
			for (int i = 0; i < cur_n[s]; i++) begin
				j = find_level(prev_px[s], prev_n[s], cur_px[s][i]);
				if (j < 0 || prev_qt[s][j] != cur_qt[s][i])
					add_event(s, cur_px[s][i], cur_qt[s][i], ts);
			end
			for (int i = 0; i < prev_n[s]; i++)
				if (find_level(cur_px[s], cur_n[s], prev_px[s][i]) < 0)
					add_event(s, prev_px[s][i], '0, ts);
		end
		if (expected_events.size() > n_earlier)
			expected_events[$].ev.last = 1'b1;
		prev_px = cur_px;
		prev_qt = cur_qt;
		prev_n = cur_n;
		cur_n = '{0, 0};
		first_pending = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		book_event_t e;
		int errs;
		errs = 0;
		if (!arst_n) begin
			fail_count <= 0;
			prev_n = '{0, 0};
			cur_n = '{0, 0};
			seq_next = '0;
			first_pending = 1'b1;
			none_emitted = 1'b1;
			symbol = '0;
			expected_events.delete();
		end else begin
			if (!empty && pop) begin
				if (expected_events.size() == 0) begin
					$error("event with no expectation: sequence %0d", event_sequence);
					errs++;
				end else begin
					e = expected_events.pop_front();
					if (event_sequence !== e.ev.seq) begin
						$error("event_sequence expected %0d got %0d", e.ev.seq, event_sequence);
						errs++;
					end
					if (event_price !== e.ev.price) begin
						$error("event_price expected %0h got %0h", e.ev.price, event_price);
						errs++;
					end
					if (event_qty !== e.ev.qty) begin
						$error("event_qty expected %0h got %0h", e.ev.qty, event_qty);
						errs++;
					end
					if (event_side !== e.ev.side) begin
						$error("event_side expected %0b got %0b", e.ev.side, event_side);
						errs++;
					end
					if (is_snapshot_kind !== e.ev.snap) begin
						$error("is_snapshot_kind expected %0b got %0b", e.ev.snap,
							is_snapshot_kind);
						errs++;
					end
					if (start_marker !== e.ev.start) begin
						$error("start_marker expected %0b got %0b", e.ev.start, start_marker);
						errs++;
					end
					if (event_time_ns !== e.ev.time_ns) begin
						$error("event_time_ns expected %0h got %0h", e.ev.time_ns,
							event_time_ns);
						errs++;
					end
					if (event_symbol !== e.sym) begin
						$error("event_symbol expected %0h got %0h", e.sym, event_symbol);
						errs++;
					end
					if (last_of_run !== e.ev.last) begin
						$error("last_of_run expected %0b got %0b", e.ev.last, last_of_run);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			if (cfg_we)
				symbol = cfg_wdata;
			if (push && !full) begin
				if (carries_level)
					insert_level(book_side, level_price, level_qty);
				if (snapshot_end)
					diff_snapshot(snapshot_time_ns);
			end
		end
	end
endmodule

@@ tb/order_book_snapshot_diff_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Order book snapshot differ testbench
// Drives snapshots of random and directed levels, with random gaps on both
// queues, and leaves the event checking to the checker beside the unit.
// ----------------------------------------------------------------------------
module order_book_snapshot_diff_unit_test;
	import obsd_pkg::*;

	localparam int CYCLE_LIMIT = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        push = 1'b0;
	logic        full;
	logic        book_side = 1'b0;
	logic [62:0] level_price = '0;
	logic [62:0] level_qty = '0;
	logic        carries_level = 1'b0;
	logic        snapshot_end = 1'b0;
	logic [63:0] snapshot_time_ns = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [63:0] event_sequence;
	logic [62:0] event_price;
	logic [62:0] event_qty;
	logic        event_side;
	logic        is_snapshot_kind;
	logic        start_marker;
	logic [63:0] event_time_ns;
	logic [31:0] event_symbol;
	logic        last_of_run;
	int          fail_count;
	int          pending_events;
	int          cycle_count = 0;
	// When set, both sides run without any idle cycles.
	logic        steady_flow = 1'b0;

	// A small pool of prices so that later snapshots repeat, change and
	// drop earlier levels rather than producing only new ones.
	logic [62:0] price_pool[8];

	always #5 clk = ~clk;

	order_book_snapshot_diff_unit i_dut (.*);

	order_book_snapshot_diff_unit_checker i_checker (.*);

	// Receiver: pops at random, stalling about 19 percent of the time.
	always @(posedge clk)
		pop <= steady_flow || ($urandom_range(99) >= 19);

	// The run is cut off if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Sends one request and holds it until the unit takes it. Idle cycles go
	// in front of the request, so the valid line never drops between two.
	task automatic send_request(logic s, logic [62:0] p, logic [62:0] q,
		logic lvl, logic fin, logic [63:0] ts);
		while (!steady_flow && $urandom_range(99) < 19) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		book_side <= s;
		level_price <= p;
		level_qty <= q;
		carries_level <= lvl;
		snapshot_end <= fin;
		snapshot_time_ns <= ts;
		do
			@(posedge clk);
		while (full);
	endtask

	// Waits until every expected event has come, then lets the diff settle.
	task automatic wait_idle();
		push <= 1'b0;
		while (pending_events != 0)
			@(posedge clk);
		repeat (2000)
			@(posedge clk);
	endtask

	task automatic write_symbol(logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [62:0] rand63();
		return 63'({$urandom(), $urandom()});
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// One random snapshot: pool prices mostly, with quantities drawn half of the
	// time from 0 to 3 so that unchanged levels are common.
	task automatic random_snapshot(output int sent);
		int n;
		logic [62:0] p, q;
		n = $urandom_range(99) < 10 ? $urandom_range(40, 20) : $urandom_range(8);
		sent = 0;
		for (int i = 0; i < n; i++) begin
			p = $urandom_range(3) == 0 ? rand63() : price_pool[3'($urandom_range(7))];
			q = $urandom_range(1) ? 63'($urandom_range(3)) : rand63();
			if ($urandom_range(19) == 0)
				send_request(1'($urandom()), rand63(), rand63(), 1'b0, 1'b0, rand64());
			else
				send_request(1'($urandom()), p, q, 1'b1, 1'b0, rand64());
			sent++;
		end
		// The end request carries a level about half of the time.
		send_request(1'($urandom()), price_pool[3'($urandom_range(7))], rand63(),
			1'($urandom()), 1'b1, rand64());
		sent++;
	endtask

	initial begin
		int sent, total;
		for (int i = 0; i < 8; i++)
			price_pool[i] = rand63();
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_symbol('0);
		// Directed: the first snapshot with extreme prices and quantities, a
		// repeated price and a level on the end request.
		send_request(1'b0, '1, '1, 1'b1, 1'b0, '0);
		send_request(1'b0, '0, '0, 1'b1, 1'b0, '0);
		send_request(1'b1, '1, '0, 1'b1, 1'b0, '0);
		send_request(1'b0, '0, 63'd5, 1'b1, 1'b0, '0);
		send_request(1'b0, 63'h5555_5555_5555_5555, 63'h2aaa_aaaa_aaaa_aaaa,
			1'b0, 1'b0, '1);
		send_request(1'b1, 63'd7, '1, 1'b1, 1'b1, '1);
		wait_idle();
		write_symbol('1);
		// An identical snapshot gives no events; then a full bid table
		// followed by a further price that is dropped and an overwrite.
		send_request(1'b0, '1, '1, 1'b1, 1'b0, '0);
		send_request(1'b0, '0, 63'd5, 1'b1, 1'b0, '0);
		send_request(1'b1, '1, '0, 1'b1, 1'b0, '0);
		send_request(1'b1, 63'd7, '1, 1'b1, 1'b1, 64'd1);
		for (int i = 0; i < BOOK_DEPTH; i++)
			send_request(1'b0, 63'(i * 3 + 1), 63'(i), 1'b1, 1'b0, '0);
		send_request(1'b0, 63'd2, 63'd9, 1'b1, 1'b0, '0);
		send_request(1'b0, 63'd4, 63'd9, 1'b1, 1'b0, '0);
		send_request(1'b0, '0, '0, 1'b0, 1'b1, 64'h8000_0000_0000_0000);
		wait_idle();
		write_symbol(32'h1234_5678);

		total = 0;
		while (total < 350) begin
			steady_flow <= (total >= 150 && total < 220);
			random_snapshot(sent);
			total += sent;
			if ($urandom_range(9) == 0) begin
				wait_idle();
				write_symbol($urandom());
			end
		end
		steady_flow <= 1'b0;
		wait_idle();
		write_symbol(32'h8000_0001);
		// Full ask and bid tables, one ask level, then a snapshot where all vanish.
		for (int i = 0; i < BOOK_DEPTH; i++) begin
			send_request(1'b1, rand63(), rand63(), 1'b1, 1'b0, '0);
			send_request(1'b0, rand63(), rand63(), 1'b1, 1'b0, '0);
		end
		send_request(1'b0, '0, '0, 1'b0, 1'b1, rand64());
		send_request(1'b1, rand63(), rand63(), 1'b1, 1'b1, rand64());
		send_request(1'b0, '0, '0, 1'b0, 1'b1, rand64());
		wait_idle();

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
